// ===== hdl/bale_pkg.sv =====
`timescale 1ns / 1ps

package bale_pkg;

	// Storage geometry.
	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Fixed port field widths.
	localparam int PORT_VAL_W = 32;
	localparam int CAP_W      = 5;
	localparam int POS_W      = 5;
	localparam int FIDX_W     = 4;

	// Width used for all position and count arithmetic; one spare bit so
	// that count + 1 never wraps.
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CMP_W-1:0]   cmp_t;

	typedef enum logic [2:0] {
		FN_ADD_FRONT  = 3'd0,
		FN_ADD_BACK   = 3'd1,
		FN_INSERT     = 3'd2,
		FN_TAKE_FRONT = 3'd3,
		FN_TAKE_BACK  = 3'd4,
		FN_ERASE      = 3'd5,
		FN_SEARCH     = 3'd6
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_POS   = 2'd3
	} err_t;

	// Broadcast control seen by every cell of the chain.
	typedef struct packed {
		logic ins;
		logic del;
		cmp_t at_k;
		cmp_t cnt;
	} cell_ctl_t;

endpackage

// ===== hdl/bounded_array_list_engine.sv =====
`timescale 1ns / 1ps

// Ordered list of up to capacity_limit signed values, held in a chain of
// register cells. Every accepted item is one request (push front or back,
// insert at a 1-based position, pop front or back, erase at a 1-based
// position, or search) and produces exactly one result item carrying the
// removed value, the search outcome, an error code and the list status
// after the request. A request is worked in the cycle it is accepted: all
// cells shift toward or away from the addressed slot at once, and the
// search compares every live cell in parallel, so one item is taken per
// clock while the result register is free or being drained. A result that
// waits under out_stall holds off the next item through in_stall. The
// capacity register resets to 16 and should only be written while no
// result is outstanding; values above the cell count are treated as the
// cell count. Cells have no reset; only live entries are ever reported.
module bounded_array_list_engine import bale_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: capacity_limit.
	input  logic                          wr_en,
	input  logic [CAP_W-1:0]              wr_data,
	// Request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    func,
	input  logic signed [PORT_VAL_W-1:0]  item_value,
	input  logic [POS_W-1:0]              slot_position,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [PORT_VAL_W-1:0]  removed_value,
	output logic                          found_flag,
	output logic [FIDX_W-1:0]             found_index,
	output logic [1:0]                    error_code,
	output logic [CAP_W-1:0]              entry_count,
	output logic                          is_empty,
	output logic signed [PORT_VAL_W-1:0]  front_value,
	output logic signed [PORT_VAL_W-1:0]  back_value
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic             accept;

	value_t    cells_q [DEPTH];
	value_t    cells_d [DEPTH];
	logic      match   [DEPTH];
	cell_ctl_t ctl;
	value_t    new_val;

	// Request decode.
	func_t      fn;
	cmp_t       cnt_c;
	cmp_t       cap_c;
	cmp_t       cap_now;
	cmp_t       at;
	cmp_t       new_cnt;
	cmp_t       back_idx;
	err_t       err;
	value_t     removed;
	logic       found;
	logic [IDX_W-1:0] fidx;

	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// The input value is sign-extended or cut to the stored width.
	assign new_val = VALUE_W'(item_value);

	assign fn    = func_t'(func);
	assign cnt_c = cmp_t'(count_q);
	assign cap_c = cmp_t'(cap_q);

	always_comb begin
		cap_now = (cap_c > cmp_t'(DEPTH)) ? cmp_t'(DEPTH) : cap_c;
		at      = '0;
		new_cnt = cnt_c;
		err     = ERR_OK;
		removed = '0;
		found   = 1'b0;
		fidx    = '0;
		ctl.ins = 1'b0;
		ctl.del = 1'b0;
		ctl.at_k = '0;
		ctl.cnt  = cnt_c;

		unique case (fn)
			FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT: begin
				if (cnt_c >= cap_now) begin
					err = ERR_FULL;
				end else begin
					if (fn == FN_ADD_FRONT) begin
						at = cmp_t'(1);
					end else if (fn == FN_ADD_BACK) begin
						at = cnt_c + cmp_t'(1);
					end else begin
						at = cmp_t'(slot_position);
					end
					if (at == '0 || at > cnt_c + cmp_t'(1)) begin
						err = ERR_POS;
					end else begin
						ctl.ins  = accept;
						ctl.at_k = at - cmp_t'(1);
						new_cnt  = cnt_c + cmp_t'(1);
					end
				end
			end
			FN_TAKE_FRONT, FN_TAKE_BACK, FN_ERASE: begin
				if (cnt_c == '0) begin
					err = ERR_EMPTY;
				end else begin
					if (fn == FN_TAKE_FRONT) begin
						at = cmp_t'(1);
					end else if (fn == FN_TAKE_BACK) begin
						at = cnt_c;
					end else begin
						at = cmp_t'(slot_position);
					end
					if (at == '0 || at > cnt_c) begin
						err = ERR_POS;
					end else begin
						ctl.del  = accept;
						ctl.at_k = at - cmp_t'(1);
						removed  = cells_q[ctl.at_k[IDX_W-1:0]];
						new_cnt  = cnt_c - cmp_t'(1);
					end
				end
			end
			FN_SEARCH: begin
				// First live match wins; cells report live matches only.
				for (int i = 0; i < DEPTH; i++) begin
					if (!found && match[i]) begin
						found = 1'b1;
						fidx  = IDX_W'(i);
					end
				end
			end
			default: begin
				// Unused code: nothing changes, status is reported.
			end
		endcase
	end

	assign back_idx = new_cnt - cmp_t'(1);

	// Chain of cells; the ends see zero from outside.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		value_t left_v;
		value_t right_v;
		if (g == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cells_q[g+1];
		end
		bale_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.my_idx    (cmp_t'(g)),
			.left_q    (left_v),
			.right_q   (right_v),
			.new_value (new_val),
			.key       (new_val),
			.value_q   (cells_q[g]),
			.value_d   (cells_d[g]),
			.match     (match[g])
		);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (wr_en) begin
				cap_q <= wr_data;
			end
			if (accept) begin
				count_q   <= CNT_W'(new_cnt);
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result register; status reflects the list after the request.
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value <= PORT_VAL_W'(signed'(removed));
			found_flag    <= found;
			found_index   <= FIDX_W'(fidx);
			error_code    <= err;
			entry_count   <= CAP_W'(new_cnt);
			is_empty      <= (new_cnt == '0);
			front_value   <= (new_cnt != '0) ? PORT_VAL_W'(signed'(cells_d[0])) : '0;
			back_value    <= (new_cnt != '0) ?
				PORT_VAL_W'(signed'(cells_d[back_idx[IDX_W-1:0]])) : '0;
		end
	end

	// The list never grows past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_t'(count_q) <= cmp_t'(DEPTH))
		else $error("entry count exceeds cell count");

	// The count moves only on an accepted item, and by one at most.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			($past(accept) && ((cmp_t'(count_q) == cmp_t'($past(count_q)) + cmp_t'(1)) ||
			(cmp_t'(count_q) + cmp_t'(1) == cmp_t'($past(count_q))))))
		else $error("entry count changed without a valid request");

	// A delivered result agrees with the live count it reports.
	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((CNT_W'(entry_count) == count_q) &&
			(is_empty == (count_q == '0))))
		else $error("result status disagrees with list state");

	// An accepted item always leaves a result pending.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

endmodule

// ===== hdl/bale_cell.sv =====
`timescale 1ns / 1ps

module bale_cell import bale_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  cmp_t      my_idx,
	input  value_t    left_q,
	input  value_t    right_q,
	input  value_t    new_value,
	input  value_t    key,
	output value_t    value_q,
	output value_t    value_d,
	output logic      match
);

	cmp_t idx_plus1;

	assign idx_plus1 = my_idx + cmp_t'(1);

	always_comb begin
		value_d = value_q;
		if (ctl.ins) begin
			if (my_idx == ctl.at_k) begin
				value_d = new_value;
			end else if (my_idx > ctl.at_k && my_idx <= ctl.cnt) begin
				value_d = left_q;
			end
		end else if (ctl.del) begin
			if (my_idx >= ctl.at_k && idx_plus1 < ctl.cnt) begin
				value_d = right_q;
			end
		end
	end

	// Only live cells take part in a search.
	assign match = (my_idx < ctl.cnt) && (value_q == key);

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

// ===== sim/bounded_array_list_engine_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounded list engine. Every accepted request item
// is run through a local model of the list at the moment it is accepted. The
// model's outcome is queued, and each accepted result item is checked field
// by field against the oldest queued outcome.
module bounded_array_list_engine_tb;
	import bale_pkg::*;

	// Function code 7 has no meaning in the block; it must leave the list alone.
	localparam logic [2:0] FN_UNUSED = 3'd7;

	// Generous watchdog for a run of roughly 2000 items.
	localparam int CYCLE_LIMIT = 300000;

	// Everything one result item carries, in port order.
	typedef struct packed {
		logic [PORT_VAL_W-1:0] removed;
		logic                  found;
		logic [FIDX_W-1:0]     fidx;
		logic [1:0]            err;
		logic [CAP_W-1:0]      count;
		logic                  empty;
		logic [PORT_VAL_W-1:0] front;
		logic [PORT_VAL_W-1:0] back;
	} list_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         wr_en = 1'b0;
	logic [CAP_W-1:0]             wr_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [2:0]                   func = '0;
	logic signed [PORT_VAL_W-1:0] item_value = '0;
	logic [POS_W-1:0]             slot_position = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [PORT_VAL_W-1:0] removed_value;
	logic                         found_flag;
	logic [FIDX_W-1:0]            found_index;
	logic [1:0]                   error_code;
	logic [CAP_W-1:0]             entry_count;
	logic                         is_empty;
	logic signed [PORT_VAL_W-1:0] front_value;
	logic signed [PORT_VAL_W-1:0] back_value;

	// Local copy of the list contents, its length and the capacity register.
	logic [PORT_VAL_W-1:0] list_q [DEPTH];
	int                    live_q = 0;
	int                    cap_q = int'(CAP_RESET);

	list_result_t pending_results [$];
	int           error_count = 0;
	int           cycle_count = 0;
	// When set, neither side idles; this gives one long back-to-back stretch.
	bit           quiet_mode = 1'b0;
	// Cycles that the receiver still has to hold off for the pressure test.
	int           hold_left = 0;

	bounded_array_list_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.item_value    (item_value),
		.slot_position (slot_position),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.removed_value (removed_value),
		.found_flag    (found_flag),
		.found_index   (found_index),
		.error_code    (error_code),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.front_value   (front_value),
		.back_value    (back_value)
	);

	always #5 clk = ~clk;

	// Applies one request to the local list and returns the result item that
	// the block should produce for it. Capacities above the cell count act as
	// the cell count. For adds, the full check comes before the position check.
	function automatic list_result_t apply_request(input logic [2:0] fn,
			input logic [PORT_VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t r;
		int           lim;
		int           at;
		int           i;
		r = '0;
		lim = (cap_q > DEPTH) ? DEPTH : cap_q;
		case (fn)
			FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT: begin
				if (live_q >= lim) begin
					r.err = ERR_FULL;
				end else begin
					at = (fn == FN_ADD_FRONT) ? 1 : (fn == FN_ADD_BACK) ? live_q + 1 : int'(pos);
					if (at < 1 || at > live_q + 1) begin
						r.err = ERR_POS;
					end else begin
						for (i = live_q; i >= at; i--)
							list_q[i] = list_q[i-1];
						list_q[at-1] = val;
						live_q++;
					end
				end
			end
			FN_TAKE_FRONT, FN_TAKE_BACK, FN_ERASE: begin
				if (live_q == 0) begin
					r.err = ERR_EMPTY;
				end else begin
					at = (fn == FN_TAKE_FRONT) ? 1 : (fn == FN_TAKE_BACK) ? live_q : int'(pos);
					if (at < 1 || at > live_q) begin
						r.err = ERR_POS;
					end else begin
						r.removed = list_q[at-1];
						for (i = at; i < live_q; i++)
							list_q[i-1] = list_q[i];
						live_q--;
					end
				end
			end
			FN_SEARCH: begin
				// Only live entries take part, and the first match wins.
				for (i = 0; i < live_q; i++) begin
					if (list_q[i] == val) begin
						r.found = 1'b1;
						r.fidx = FIDX_W'(i);
						break;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = CAP_W'(live_q);
		r.empty = (live_q == 0);
		r.front = (live_q != 0) ? list_q[0] : '0;
		r.back = (live_q != 0) ? list_q[live_q-1] : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [PORT_VAL_W-1:0] want,
			input logic [PORT_VAL_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
			error_count++;
		end
	endtask

	// Offers one request item, waits for it to be taken and records the
	// outcome. The task is entered and left at a falling edge, with valid still
	// high, so the next call can keep the channel busy without a gap.
	task automatic send_request(input logic [2:0] fn, input logic [PORT_VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int           gap;
		list_result_t expected;
		if (!quiet_mode && $urandom_range(99) < 8) begin
			gap = $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = fn;
		item_value = val;
		slot_position = pos;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		expected = apply_request(fn, val, pos);
		pending_results.insert(pending_results.size(), expected);
		@(negedge clk);
	endtask

	task automatic wait_drained;
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// The capacity is changed only with nothing in flight. Every item gives a
	// result, so an empty queue plus a few cycles means the block is idle.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		repeat (3) @(negedge clk);
		wr_en = 1'b1;
		wr_data = cap;
		cap_q = int'(cap);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Builds one random request. add_pct steers the mix toward growing or
	// shrinking the list so that both the full and the empty edges are hit.
	// Values are often taken from the list itself so that searches hit.
	task automatic send_random_request(input int add_pct);
		int                    r;
		logic [2:0]            fn;
		logic [PORT_VAL_W-1:0] val;
		logic [POS_W-1:0]      pos;
		r = $urandom_range(99);
		if (r < 2)
			fn = FN_UNUSED;
		else if (r < 14)
			fn = FN_SEARCH;
		else if (r < 14 + (add_pct * 86) / 100)
			fn = 3'($urandom_range(2));
		else
			fn = 3'(3 + $urandom_range(2));
		case ($urandom_range(3))
			0: val = (live_q != 0) ? list_q[$urandom_range(live_q - 1)] : '0;
			1: val = $urandom_range(8) - 4;
			2: val = $urandom;
			default: begin
				case ($urandom_range(3))
					0: val = 32'h7fff_ffff;
					1: val = 32'h8000_0000;
					2: val = 32'h0000_0000;
					default: val = 32'hffff_ffff;
				endcase
			end
		endcase
		// Mostly positions in or just past the live range; some anywhere.
		if ($urandom_range(9) == 0)
			pos = POS_W'($urandom_range(31));
		else
			pos = POS_W'($urandom_range(1, live_q + 1));
		send_request(fn, val, pos);
	endtask

	// A freshly reset list: every removal reports empty, search misses.
	task automatic test_empty_list;
		send_request(FN_SEARCH, 32'd5, 5'd0);
		send_request(FN_TAKE_FRONT, 32'd0, 5'd1);
		send_request(FN_TAKE_BACK, 32'd0, 5'd1);
		send_request(FN_ERASE, 32'd0, 5'd1);
		send_request(FN_UNUSED, 32'd0, 5'd0);
	endtask

	// Adds at both ends and at positions, with the value extremes, then
	// insert positions outside the valid range of 1 to count+1.
	task automatic test_add_and_position;
		send_request(FN_ADD_BACK, 32'h7fff_ffff, 5'd0);
		send_request(FN_ADD_FRONT, 32'h8000_0000, 5'd31);
		send_request(FN_INSERT, 32'h0000_0000, 5'd2);
		send_request(FN_INSERT, 32'hffff_ffff, 5'd4);
		send_request(FN_INSERT, 32'h1234_5678, 5'd0);
		send_request(FN_INSERT, 32'h1234_5678, 5'd6);
		send_request(FN_INSERT, 32'h1234_5678, 5'd31);
	endtask

	// Search hit and miss, erase positions outside 1 to count, then each kind
	// of removal on a valid target.
	task automatic test_search_and_remove;
		send_request(FN_SEARCH, 32'hffff_ffff, 5'd0);
		send_request(FN_SEARCH, 32'h0001_2345, 5'd0);
		send_request(FN_ERASE, 32'd0, 5'd0);
		send_request(FN_ERASE, 32'd0, 5'd5);
		send_request(FN_ERASE, 32'd0, 5'd2);
		send_request(FN_TAKE_BACK, 32'd0, 5'd0);
		send_request(FN_TAKE_FRONT, 32'd0, 5'd0);
	endtask

	// Capacity edges: a limit of one, a limit of zero with an entry left over,
	// and a value above the cell count, which acts as the cell count.
	task automatic test_capacity_edges;
		write_capacity(5'd1);
		send_request(FN_ADD_BACK, 32'd9, 5'd0);
		// Full is reported even though the position is also bad.
		send_request(FN_INSERT, 32'd9, 5'd31);
		write_capacity(5'd0);
		send_request(FN_TAKE_FRONT, 32'd0, 5'd0);
		send_request(FN_ADD_BACK, 32'd3, 5'd0);
		write_capacity(5'd31);
		send_request(FN_ADD_FRONT, 32'd1, 5'd0);
		write_capacity(CAP_RESET);
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering items, so the result register fills and the input stalls.
	task automatic test_result_backpressure;
		int n;
		hold_left = 60;
		for (n = 0; n < 20; n++)
			send_random_request(50);
	endtask

	// Random traffic in phases, one capacity setting per phase. Each phase
	// first grows the list and then drains it. One phase runs with no idling.
	task automatic test_random_traffic;
		logic [CAP_W-1:0] caps [7];
		int               p;
		int               n;
		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd2, 5'd16};
		caps[6] = CAP_W'($urandom_range(1, 16));
		for (p = 0; p < 7; p++) begin
			write_capacity(caps[p]);
			quiet_mode = (p == 4);
			for (n = 0; n < 270; n++)
				send_random_request((n < 135) ? 65 : 35);
		end
		quiet_mode = 1'b0;
	endtask

	// The receiver changes out_stall on the falling edge: a counted hold-off
	// when one is pending, otherwise random short stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall = !quiet_mode && ($urandom_range(99) < 8);
		end
	end

	// Each accepted result item is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual count %h",
					$realtime, entry_count);
				error_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				check_field("removed_value", want.removed, removed_value);
				check_field("found_flag", 32'(want.found), 32'(found_flag));
				check_field("found_index", 32'(want.fidx), 32'(found_index));
				check_field("error_code", 32'(want.err), 32'(error_code));
				check_field("entry_count", 32'(want.count), 32'(entry_count));
				check_field("is_empty", 32'(want.empty), 32'(is_empty));
				check_field("front_value", want.front, front_value);
				check_field("back_value", want.back, back_value);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_array_list_engine_tb: done, errors");
			$finish;
		end
	end

	initial begin
		// Reset is held low from time zero and released on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_list();
		test_add_and_position();
		test_search_and_remove();
		test_capacity_edges();
		test_result_backpressure();
		test_random_traffic();

		// Let the last results drain and give the block a few idle cycles.
		wait_drained();
		repeat (5) @(posedge clk);
		if (error_count == 0) begin
			$display("bounded_array_list_engine_tb: done, clean");
		end else begin
			$display("bounded_array_list_engine_tb: done, errors");
		end
		$finish;
	end

endmodule
